FILE: sv/length_prefix_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit_defines
// Assertion macros used by the deframer core.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_DEFINES_SVH

// Clocked check, masked while reset is high.
`define LPD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lpd: assertion failed");

// Clocked check that also holds during reset.
`define LPD_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("lpd: assertion failed");

`endif

FILE: sv/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   // header is four bytes, big-endian
   localparam logic [2:0]  HDR_BYTES     = 3'd4;
   localparam logic [2:0]  HDR_LAST      = 3'd3;
   localparam logic [31:0] MAX_LEN_RESET = 32'd5242880;
   localparam int          BYTE_BITS     = 8;

   // register file: one 32-bit register at byte address 0
   localparam int         CSR_ADDR_W  = 3;
   localparam logic [0:0] REG_MAX_LEN = 1'b0;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 last_of_message;
   } result_type;

endpackage

FILE: sv/lpd_stream_if.sv
// ----------------------------------------------------------------------------
// lpd_stream_if
// Valid/ready channels for incoming bytes and outgoing results.
// ----------------------------------------------------------------------------
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic       last_of_message;

   modport source (output valid, output kind, output payload_byte,
                   output last_of_message, input ready);
   modport sink   (input valid, input kind, input payload_byte,
                   input last_of_message, output ready);
endinterface

FILE: sv/lpd_csr.sv
// ----------------------------------------------------------------------------
// lpd_csr
// APB register holding the maximum payload length.
// ----------------------------------------------------------------------------
module lpd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [31:0]                   max_len
);

   logic [31:0] max_len_ff;
   logic [31:0] max_len_in;
   logic        reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[lpd_pkg::CSR_ADDR_W-1:2] == lpd_pkg::REG_MAX_LEN);

   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && reg_hit) begin
         max_len_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lpd_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign prdata  = reg_hit ? max_len_ff : 32'd0;
   assign max_len = max_len_ff;

endmodule

FILE: sv/lpd_core.sv
// ----------------------------------------------------------------------------
// lpd_core
// Input register and framing state; decodes one byte per cycle while the result register is free.
// ----------------------------------------------------------------------------
`include "length_prefix_deframer_unit_defines.svh"

module lpd_core (
   input  logic                clock,
   input  logic                reset,
   lpd_req_if.sink             req,
   input  logic [31:0]         max_len,
   input  logic                out_free,
   output lpd_pkg::result_type res
);

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       fire;

   logic [2:0]  header_count_ff, header_count_in;
   logic [31:0] length_word_ff,  length_word_in;
   logic [31:0] payload_count_ff, payload_count_in;
   logic        error_stuck_ff,  error_stuck_in;

   logic [31:0] len_shift;
   logic [31:0] pc_next;

   // the held byte moves on once the result register can take it
   assign fire      = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;

   assign s1_valid_in = req.ready ? req.valid : s1_valid_ff;

   assign len_shift = {length_word_ff[31-lpd_pkg::BYTE_BITS:0], s1_byte_ff};
   assign pc_next   = payload_count_ff + 32'd1;

   always_comb begin
      header_count_in  = header_count_ff;
      length_word_in   = length_word_ff;
      payload_count_in = payload_count_ff;
      error_stuck_in   = error_stuck_ff;
      res              = '0;
      if (fire && !error_stuck_ff) begin
         if (header_count_ff < lpd_pkg::HDR_BYTES) begin
            header_count_in = header_count_ff + 3'd1;
            length_word_in  = len_shift;
            if (header_count_ff == lpd_pkg::HDR_LAST) begin
               if (len_shift > max_len) begin
                  error_stuck_in = 1'b1;
                  res.valid      = 1'b1;
                  res.kind       = lpd_pkg::KIND_ERROR;
               end else if (len_shift == 32'd0) begin
                  header_count_in     = 3'd0;
                  length_word_in      = 32'd0;
                  payload_count_in    = 32'd0;
                  res.valid           = 1'b1;
                  res.kind            = lpd_pkg::KIND_EMPTY;
                  res.last_of_message = 1'b1;
               end else begin
                  payload_count_in = 32'd0;
               end
            end
         end else begin
            res.valid        = 1'b1;
            res.kind         = lpd_pkg::KIND_PAYLOAD;
            res.payload_byte = s1_byte_ff;
            if (pc_next >= length_word_ff) begin
               header_count_in     = 3'd0;
               length_word_in      = 32'd0;
               payload_count_in    = 32'd0;
               res.last_of_message = 1'b1;
            end else begin
               payload_count_in = pc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         header_count_ff  <= 3'd0;
         length_word_ff   <= 32'd0;
         payload_count_ff <= 32'd0;
         error_stuck_ff   <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         header_count_ff  <= header_count_in;
         length_word_ff   <= length_word_in;
         payload_count_ff <= payload_count_in;
         error_stuck_ff   <= error_stuck_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff <= req.data_byte;
      end
   end

   `LPD_ASSERT(a_error_sticky, error_stuck_ff |=> error_stuck_ff)
   `LPD_ASSERT(a_error_sets_stuck, (res.valid && res.kind == lpd_pkg::KIND_ERROR) |=> error_stuck_ff)
   `LPD_ASSERT_ALWAYS(a_no_result_when_stuck, error_stuck_ff |-> !res.valid)
   `LPD_ASSERT(a_header_count_range, header_count_ff <= lpd_pkg::HDR_BYTES)

endmodule

FILE: sv/lpd_out.sv
// ----------------------------------------------------------------------------
// lpd_out
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module lpd_out (
   input  logic                clock,
   input  logic                reset,
   input  lpd_pkg::result_type res,
   output logic                out_free,
   lpd_rsp_if.source           rsp
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lpd_pkg::result_type rsp_data_ff;

   // free when empty or the held beat leaves this cycle
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = out_free ? res.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res.valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.kind            = rsp_data_ff.kind;
   assign rsp.payload_byte    = rsp_data_ff.payload_byte;
   assign rsp.last_of_message = rsp_data_ff.last_of_message;

endmodule

FILE: sv/length_prefix_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit
// Splits a byte stream into messages with a 4-byte big-endian length header.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw stream byte per beat. rsp_chan carries one
//   result per beat: a payload byte (last_of_message on the final one), an
//   empty-message marker for a zero length, or an oversize error when the
//   header length exceeds max_payload_len. Header bytes produce no beat
//   unless the length is zero or oversize. After an error the block drops
//   every byte until reset. max_payload_len sits at byte address 0 of the
//   APB port; write it only while no byte is in flight.
// Timing:
//   A byte accepted into the input register is decoded there and its result
//   is captured in the result register, which drives rsp_chan. One byte per
//   cycle is sustained while rsp_chan is not held off; the input register,
//   the decode logic and the result register form one registered pass with
//   no iteration.
// Reset: clears the framing state and the sticky error and restores the
//   maximum to 5242880; no clearing pass is needed.
// Stall: while rsp_chan is held off, the result register holds its beat;
//   an empty input register takes one more byte, then req_chan.ready drops.
// ----------------------------------------------------------------------------
module length_prefix_deframer_unit (
   input  logic                          clock,
   input  logic                          reset,
   lpd_req_if.sink                       req_chan,
   lpd_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lpd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [31:0]         max_len;
   logic                out_free;
   lpd_pkg::result_type res;

   // hold the length limit
   lpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .max_len (max_len)
   );

   // register the byte, advance header/payload counters, form the result
   lpd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .max_len  (max_len),
      .out_free (out_free),
      .res      (res)
   );

   // hold the result beat until the receiver takes it
   lpd_out u_out (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .out_free (out_free),
      .rsp      (rsp_chan)
   );

endmodule
